// ----- rtl/pss_pkg.sv -----
// pss_pkg: shared constants for the proximity shock sequencer
// phase codes, register indexes and result beat layout
// no dependencies
package pss_pkg;

  localparam int TS_W    = 32;
  localparam int CNT_W   = 32;
  localparam int LAT_W   = 16;
  localparam int RAD_W   = 12;
  localparam int RSQ_W   = 2 * RAD_W;
  localparam int LVL_W   = 3;
  localparam int PHASE_W = 3;

  // sequencer phases
  localparam logic [PHASE_W-1:0] PH_OUTSIDE = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LATENCY = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SHOCK   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_PAUSE   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_REFRACT = 3'd4;

  // register indexes (byte address / 4)
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ENTRANCE   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_INTERSHOCK = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DURATION   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REFRACTORY = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LEVEL      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE     = 3'd6;
  localparam int PADDR_W = REG_IDX_W + 2;
  localparam int PDATA_W = 32;

  // result beat layout
  localparam int OUT_NEAR_LO  = 0;
  localparam int OUT_STATE_LO = 1;
  localparam int OUT_LEVEL_LO = 4;
  localparam int OUT_BAD_LO   = 7;
  localparam int OUT_DRIVE_LO = 8;
  localparam int OUT_GOOD_LO  = 11;
  localparam int OUT_BADC_LO  = OUT_GOOD_LO + CNT_W;
  localparam int OUT_ENTRY_LO = OUT_BADC_LO + CNT_W;
  localparam int OUT_SHOCK_LO = OUT_ENTRY_LO + CNT_W;
  localparam int OUT_FIRST_LO = OUT_SHOCK_LO + CNT_W;
  localparam int OUT_BITS     = OUT_FIRST_LO + TS_W;
  localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8;

endpackage

// ----- rtl/proximity_shock_sequencer.sv -----
// proximity_shock_sequencer: distance check and five-phase shock sequencer
// four-stage pipeline: abs diffs, squares, near compare, sequencer update
// depends on pss_pkg
//
//   channel  | dir | beat contents
//   ---------+-----+--------------------------------------------------------
//   s_axis   | in  | one video frame: timestamp, two tracked spots
//   m_axis   | out | one result per frame: flags, phases, level, counters
//   apb      | in  | seven config registers at byte address 4*i, read back
//
// one frame per cycle while m_axis takes results; a result is valid once its
// beat has passed the abs-diff, square and compare registers and the
// sequencer stage, whose state lives in one register set.
// the whole pipe moves only when the output register is empty or taken,
// so a stall on m_axis holds every stage and s_tready drops with it.
// rst is synchronous: phase outside, counters and config registers zero.
module proximity_shock_sequencer
  import pss_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             s_tvalid,
  output logic                                             s_tready,
  // timestamp_ms, subject_found, subject_x, subject_y, target_found,
  // target_x, target_y (low bits up)
  input  logic [((34 + 4 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                                             m_tvalid,
  input  logic                                             m_tready,
  // in_sector, logged_state, logged_level, bad_frame, drive_now,
  // good_total, bad_total, entry_total, shock_total, first_shock_ms
  output logic [OUT_W-1:0]                                 m_tdata,
  input  logic                                             psel,
  input  logic                                             penable,
  input  logic                                             pwrite,
  input  logic [PADDR_W-1:0]                               paddr,
  input  logic [PDATA_W-1:0]                               pwdata,
  output logic [PDATA_W-1:0]                               prdata,
  output logic                                             pready
);

  localparam int SF_BIT = TS_W;
  localparam int SX_LO  = TS_W + 1;
  localparam int SY_LO  = SX_LO + COORD_BITS;
  localparam int TF_BIT = SY_LO + COORD_BITS;
  localparam int TX_LO  = TF_BIT + 1;
  localparam int TY_LO  = TX_LO + COORD_BITS;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int CMP_W  = (SQ_W + 1 > RSQ_W) ? SQ_W + 1 : RSQ_W;

  // configuration registers
  logic [RAD_W-1:0] trigger_radius;
  logic [LAT_W-1:0] entrance_latency;
  logic [LAT_W-1:0] intershock_latency;
  logic [LAT_W-1:0] shock_duration;
  logic [LAT_W-1:0] refractory;
  logic [LVL_W-1:0] shock_level;
  logic             shock_enable;
  logic [RSQ_W-1:0] radius_sq;

  logic             cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_radius     <= '0;
      entrance_latency   <= '0;
      intershock_latency <= '0;
      shock_duration     <= '0;
      refractory         <= '0;
      shock_level        <= '0;
      shock_enable       <= 1'b0;
      radius_sq          <= '0;
    end else begin
      radius_sq <= trigger_radius * trigger_radius;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_RADIUS:     trigger_radius     <= pwdata[RAD_W-1:0];
          REG_ENTRANCE:   entrance_latency   <= pwdata[LAT_W-1:0];
          REG_INTERSHOCK: intershock_latency <= pwdata[LAT_W-1:0];
          REG_DURATION:   shock_duration     <= pwdata[LAT_W-1:0];
          REG_REFRACTORY: refractory         <= pwdata[LAT_W-1:0];
          REG_LEVEL:      shock_level        <= pwdata[LVL_W-1:0];
          REG_ENABLE:     shock_enable       <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_RADIUS:     prdata = PDATA_W'(trigger_radius);
      REG_ENTRANCE:   prdata = PDATA_W'(entrance_latency);
      REG_INTERSHOCK: prdata = PDATA_W'(intershock_latency);
      REG_DURATION:   prdata = PDATA_W'(shock_duration);
      REG_REFRACTORY: prdata = PDATA_W'(refractory);
      REG_LEVEL:      prdata = PDATA_W'(shock_level);
      REG_ENABLE:     prdata = PDATA_W'(shock_enable);
      default:        prdata = '0;
    endcase
  end

  // pipeline control
  logic advance;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  // stage 1: absolute differences
  logic [COORD_BITS-1:0] sx, sy, tx, ty;
  logic                  v1, bad1;
  logic [TS_W-1:0]       ts1;
  logic [COORD_BITS-1:0] dx1, dy1;

  assign sx = s_tdata[SX_LO +: COORD_BITS];
  assign sy = s_tdata[SY_LO +: COORD_BITS];
  assign tx = s_tdata[TX_LO +: COORD_BITS];
  assign ty = s_tdata[TY_LO +: COORD_BITS];

  // stage 2: squares
  logic            v2, bad2;
  logic [TS_W-1:0] ts2;
  logic [SQ_W-1:0] dx_sq, dy_sq;

  // stage 3: near flag
  logic            v3, bad3, near3;
  logic [TS_W-1:0] ts3;
  logic [CMP_W-1:0] dist_sq;

  assign dist_sq = CMP_W'({1'b0, dx_sq} + {1'b0, dy_sq});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ts1   <= s_tdata[TS_W-1:0];
      bad1  <= !(s_tdata[SF_BIT] && s_tdata[TF_BIT]);
      dx1   <= (sx > tx) ? sx - tx : tx - sx;
      dy1   <= (sy > ty) ? sy - ty : ty - sy;
      ts2   <= ts1;
      bad2  <= bad1;
      dx_sq <= dx1 * dx1;
      dy_sq <= dy1 * dy1;
      ts3   <= ts2;
      bad3  <= bad2;
      near3 <= !bad2 && (dist_sq < CMP_W'(radius_sq));
    end
  end

  // stage 4: sequencer state
  logic [PHASE_W-1:0] phase, phase_next;
  logic [TS_W-1:0]    last_change, last_change_next;
  logic [LVL_W-1:0]   drive_level, drive_level_next;
  logic [CNT_W-1:0]   good_count, bad_count, entry_count, shock_count;
  logic [TS_W-1:0]    first_shock, first_shock_next;
  logic               entry_inc, shock_inc;
  logic [LAT_W-1:0]   wait_sel;
  logic               elapsed;

  always_comb begin
    case (phase)
      PH_LATENCY: wait_sel = entrance_latency;
      PH_SHOCK:   wait_sel = shock_duration;
      PH_PAUSE:   wait_sel = intershock_latency;
      PH_REFRACT: wait_sel = refractory;
      default:    wait_sel = '0;
    endcase
  end

  // 33-bit sum so a late deadline never wraps
  assign elapsed = {1'b0, ts3} > ({1'b0, last_change} + (TS_W + 1)'(wait_sel));

  always_comb begin
    phase_next       = phase;
    last_change_next = last_change;
    drive_level_next = drive_level;
    first_shock_next = first_shock;
    entry_inc        = 1'b0;
    shock_inc        = 1'b0;
    case (phase)
      PH_LATENCY: begin
        if (!bad3) begin
          if (near3) begin
            if (elapsed) begin
              phase_next       = PH_SHOCK;
              shock_inc        = 1'b1;
              last_change_next = ts3;
              if (first_shock == '0) first_shock_next = ts3;
              if (shock_enable) drive_level_next = shock_level;
            end
          end else begin
            phase_next = PH_OUTSIDE;
          end
        end
      end
      PH_SHOCK: begin
        // drive drops even on a bad frame, phase waits for a good one
        if (elapsed) begin
          if (shock_enable) drive_level_next = '0;
          if (!bad3) begin
            phase_next       = near3 ? PH_PAUSE : PH_REFRACT;
            last_change_next = ts3;
          end
        end
      end
      PH_PAUSE: begin
        if (!bad3) begin
          if (near3) begin
            if (elapsed) begin
              phase_next       = PH_SHOCK;
              shock_inc        = 1'b1;
              last_change_next = ts3;
              if (shock_enable) drive_level_next = shock_level;
            end
          end else begin
            phase_next       = PH_REFRACT;
            last_change_next = ts3;
          end
        end
      end
      PH_REFRACT: begin
        if (elapsed) phase_next = PH_OUTSIDE;
      end
      default: begin
        if (near3) begin
          phase_next       = PH_LATENCY;
          entry_inc        = 1'b1;
          last_change_next = ts3;
        end
      end
    endcase
  end

  // logged fields; counters and drive come straight from the state,
  // which only moves when a new result is loaded
  logic               o_near, o_bad;
  logic [PHASE_W-1:0] o_state;
  logic [LVL_W-1:0]   o_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      phase       <= PH_OUTSIDE;
      last_change <= '0;
      drive_level <= '0;
      good_count  <= '0;
      bad_count   <= '0;
      entry_count <= '0;
      shock_count <= '0;
      first_shock <= '0;
    end else if (advance) begin
      m_tvalid <= v3;
      if (v3) begin
        phase       <= phase_next;
        last_change <= last_change_next;
        drive_level <= drive_level_next;
        first_shock <= first_shock_next;
        good_count  <= good_count + CNT_W'(!bad3);
        bad_count   <= bad_count + CNT_W'(bad3);
        entry_count <= entry_count + CNT_W'(entry_inc);
        shock_count <= shock_count + CNT_W'(shock_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v3) begin
      o_near  <= near3;
      o_bad   <= bad3;
      o_state <= phase;
      o_level <= drive_level;
    end
  end

  assign m_tdata = OUT_W'({first_shock, shock_count, entry_count, bad_count, good_count,
                           drive_level, o_bad, o_level, o_state, o_near});

endmodule

// ----- rtl/pss_checker.sv -----
// pss_checker: port-level checks on the result stream of the sequencer
// bound to proximity_shock_sequencer; depends on pss_pkg
module pss_checker
  import pss_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  logic             out_beat;
  logic             seen;
  logic [CNT_W-1:0] frame_sum, last_sum;

  assign out_beat  = m_tvalid && m_tready;
  assign frame_sum = m_tdata[OUT_GOOD_LO +: CNT_W] + m_tdata[OUT_BADC_LO +: CNT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      seen     <= 1'b0;
      last_sum <= '0;
    end else if (out_beat) begin
      seen     <= 1'b1;
      last_sum <= frame_sum;
    end
  end

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // a bad frame is never near
  a_bad_not_near: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[OUT_BAD_LO] && m_tdata[OUT_NEAR_LO]))
    else $error("bad frame flagged in sector");

  // every frame counts once, good or bad
  a_frame_count: assert property (@(posedge clk) disable iff (rst)
    out_beat && seen |-> frame_sum == last_sum + CNT_W'(1))
    else $error("frame counters skipped or repeated");

  // nothing leaves right after reset
  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind proximity_shock_sequencer pss_checker u_pss_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- dv/proximity_shock_sequencer_tb.sv -----
// proximity_shock_sequencer_tb: frame stream test of the proximity shock sequencer
// predicts each result beat with its own sequencer model and checks it field by field
// depends on pss_pkg and rtl/proximity_shock_sequencer.sv
module proximity_shock_sequencer_tb;
  import pss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB          = 12;
  localparam int IN_W        = ((34 + 4 * CB + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_ITEMS = 80;

  typedef struct packed {
    logic [IN_W-34-4*CB-1:0] pad;
    logic [CB-1:0]           target_y;
    logic [CB-1:0]           target_x;
    logic                    target_found;
    logic [CB-1:0]           subject_y;
    logic [CB-1:0]           subject_x;
    logic                    subject_found;
    logic [TS_W-1:0]         timestamp_ms;
  } frame_t;

  typedef struct packed {
    logic [OUT_W-OUT_BITS-1:0] pad;
    logic [TS_W-1:0]           first_shock_ms;
    logic [CNT_W-1:0]          shock_total;
    logic [CNT_W-1:0]          entry_total;
    logic [CNT_W-1:0]          bad_total;
    logic [CNT_W-1:0]          good_total;
    logic [LVL_W-1:0]          drive_now;
    logic                      bad_frame;
    logic [LVL_W-1:0]          logged_level;
    logic [PHASE_W-1:0]        logged_state;
    logic                      in_sector;
  } result_t;

  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [LAT_W-1:0] entrance;
    logic [LAT_W-1:0] intershock;
    logic [LAT_W-1:0] duration;
    logic [LAT_W-1:0] refractory;
    logic [LVL_W-1:0] level;
    logic             enable;
  } shock_cfg_t;

  class shock_scoreboard;
    shock_cfg_t         cfg;
    logic [PHASE_W-1:0] phase;
    logic [TS_W-1:0]    changed_at;
    logic [LVL_W-1:0]   drive;
    logic [CNT_W-1:0]   n_good, n_bad, n_entry, n_shock;
    logic [TS_W-1:0]    first_shock;
    result_t            expected_q[$];
    int                 errors;

    function new();
      cfg         = '0;
      phase       = PH_OUTSIDE;
      changed_at  = '0;
      drive       = '0;
      n_good      = '0;
      n_bad       = '0;
      n_entry     = '0;
      n_shock     = '0;
      first_shock = '0;
      errors      = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // elapsed check, sum formed at 33 bits so it never wraps
    function bit elapsed(logic [TS_W-1:0] now, logic [LAT_W-1:0] hold_ms);
      logic [TS_W:0] limit;
      limit = {1'b0, changed_at} + (TS_W + 1)'(hold_ms);
      return {1'b0, now} > limit;
    endfunction

    function void set_drive(logic [LVL_W-1:0] lvl);
      if (cfg.enable) drive = lvl;
    endfunction

    function void note_frame(frame_t f);
      result_t        r;
      logic           bad, near;
      logic [CB-1:0]  dx, dy;
      logic [2*CB:0]  dist2;
      logic [2*CB:0]  rad2;
      r = '0;
      r.logged_state = phase;
      r.logged_level = drive;
      bad  = !(f.subject_found && f.target_found);
      near = 1'b0;
      if (bad) begin
        n_bad++;
      end else begin
        dx    = (f.subject_x > f.target_x) ? f.subject_x - f.target_x : f.target_x - f.subject_x;
        dy    = (f.subject_y > f.target_y) ? f.subject_y - f.target_y : f.target_y - f.subject_y;
        dist2 = dx * dx + dy * dy;
        rad2  = cfg.radius * cfg.radius;
        near  = dist2 < rad2;
        n_good++;
      end
      case (phase)
        PH_LATENCY: begin
          if (!bad) begin
            if (near) begin
              if (elapsed(f.timestamp_ms, cfg.entrance)) begin
                phase = PH_SHOCK;
                n_shock++;
                if (first_shock == 0) first_shock = f.timestamp_ms;
                changed_at = f.timestamp_ms;
                set_drive(cfg.level);
              end
            end else begin
              phase = PH_OUTSIDE;
            end
          end
        end
        PH_SHOCK: begin
          // a bad frame may end the drive but leaves phase and time alone
          if (elapsed(f.timestamp_ms, cfg.duration)) begin
            set_drive('0);
            if (!bad) begin
              phase      = near ? PH_PAUSE : PH_REFRACT;
              changed_at = f.timestamp_ms;
            end
          end
        end
        PH_PAUSE: begin
          if (!bad) begin
            if (near) begin
              if (elapsed(f.timestamp_ms, cfg.intershock)) begin
                phase = PH_SHOCK;
                n_shock++;
                changed_at = f.timestamp_ms;
                set_drive(cfg.level);
              end
            end else begin
              phase      = PH_REFRACT;
              changed_at = f.timestamp_ms;
            end
          end
        end
        PH_REFRACT: begin
          if (elapsed(f.timestamp_ms, cfg.refractory)) phase = PH_OUTSIDE;
        end
        default: begin
          if (near) begin
            phase = PH_LATENCY;
            n_entry++;
            changed_at = f.timestamp_ms;
          end
        end
      endcase
      r.in_sector      = near;
      r.bad_frame      = bad;
      r.drive_now      = drive;
      r.good_total     = n_good;
      r.bad_total      = n_bad;
      r.entry_total    = n_entry;
      r.shock_total    = n_shock;
      r.first_shock_ms = first_shock;
      expected_q = {expected_q, r};
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result beat with no frame outstanding");
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare("in_sector", exp_r.in_sector, got.in_sector);
      compare("logged_state", exp_r.logged_state, got.logged_state);
      compare("logged_level", exp_r.logged_level, got.logged_level);
      compare("bad_frame", exp_r.bad_frame, got.bad_frame);
      compare("drive_now", exp_r.drive_now, got.drive_now);
      compare("good_total", exp_r.good_total, got.good_total);
      compare("bad_total", exp_r.bad_total, got.bad_total);
      compare("entry_total", exp_r.entry_total, got.entry_total);
      compare("shock_total", exp_r.shock_total, got.shock_total);
      compare("first_shock_ms", exp_r.first_shock_ms, got.first_shock_ms);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // timestamp_ms, subject_found, subject_x, subject_y, target_found, target_x, target_y
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // in_sector, logged_state, logged_level, bad_frame, drive_now, good_total,
  // bad_total, entry_total, shock_total, first_shock_ms
  logic [OUT_W-1:0]     m_tdata;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  proximity_shock_sequencer #(.COORD_BITS(CB)) DUT (.*);

  shock_scoreboard sb = new();
  frame_t          frames_to_send[$];
  int              send_idle_pct = 34;
  int              recv_idle_pct = 57;
  logic            pressure_armed = 1'b0;
  logic            hold_done = 1'b0;
  int              hold_cnt = 0;
  int              cycles = 0;
  logic [TS_W-1:0] cur_ts;
  logic [RAD_W-1:0] cur_radius;
  bit              go_near = 1'b0;
  int              run_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // input beats are noted before output beats are checked
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_frame(frame_t'(s_tdata));
      if (m_tvalid && m_tready) sb.check_result(result_t'(m_tdata));
    end
  end

  // receiver: random stalls, plus one long hold-off once armed
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (pressure_armed && !hold_done) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_config(input shock_cfg_t c);
    apb_write(REG_RADIUS, PDATA_W'(c.radius));
    apb_write(REG_ENTRANCE, PDATA_W'(c.entrance));
    apb_write(REG_INTERSHOCK, PDATA_W'(c.intershock));
    apb_write(REG_DURATION, PDATA_W'(c.duration));
    apb_write(REG_REFRACTORY, PDATA_W'(c.refractory));
    apb_write(REG_LEVEL, PDATA_W'(c.level));
    apb_write(REG_ENABLE, PDATA_W'(c.enable));
    sb.cfg     = c;
    cur_radius = c.radius;
  endtask

  task automatic send_frames();
    bit offered;
    offered = 1'b0;
    while (frames_to_send.size() > 0) begin
      @(posedge clk);
      if (s_tvalid && !s_tready) continue;
      if ($urandom_range(99) < send_idle_pct) begin
        s_tvalid <= 1'b0;
        continue;
      end
      s_tdata  <= frames_to_send.pop_front();
      s_tvalid <= 1'b1;
      offered  = 1'b1;
    end
    if (offered) begin
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  // pipe is four stages deep, so a short pause after the last result is plenty
  task automatic drain();
    // wait for a clock edge first so the last input beat is already noted
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic void add_frame(logic [TS_W-1:0] ts, logic sf, int sx, int sy,
                                    logic tf, int tx, int ty);
    frame_t f;
    f = '0;
    f.timestamp_ms  = ts;
    f.subject_found = sf;
    f.subject_x     = sx[CB-1:0];
    f.subject_y     = sy[CB-1:0];
    f.target_found  = tf;
    f.target_x      = tx[CB-1:0];
    f.target_y      = ty[CB-1:0];
    frames_to_send = {frames_to_send, f};
  endfunction

  function automatic logic [CB-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > (1 << CB) - 1) return '1;
    return v[CB-1:0];
  endfunction

  // near/far runs with mostly small time steps so the sequencer walks its phases
  function automatic frame_t make_frame();
    frame_t f;
    int     roll, half;
    f    = '0;
    roll = $urandom_range(99);
    if (roll < 4) cur_ts = $urandom;
    else if (roll < 8) cur_ts = cur_ts - $urandom_range(50);
    else if (roll < 12) cur_ts = cur_ts + $urandom_range(70000);
    else cur_ts = cur_ts + $urandom_range(12);
    if (run_left == 0) begin
      go_near  = !go_near;
      run_left = $urandom_range(12, 1);
    end
    run_left--;
    f.timestamp_ms  = cur_ts;
    f.target_x      = CB'($urandom);
    f.target_y      = CB'($urandom);
    f.subject_found = 1'b1;
    f.target_found  = 1'b1;
    if (go_near) begin
      half        = cur_radius / 2;
      f.subject_x = clamp_coord(int'(f.target_x) + int'($urandom_range(2 * half)) - half);
      f.subject_y = clamp_coord(int'(f.target_y) + int'($urandom_range(2 * half)) - half);
    end else begin
      f.subject_x = CB'($urandom);
      f.subject_y = CB'($urandom);
    end
    if ($urandom_range(99) < 10) {f.subject_found, f.target_found} = 2'($urandom_range(2));
    return f;
  endfunction

  function automatic shock_cfg_t phase_config(int k);
    shock_cfg_t c;
    c.radius     = RAD_W'($urandom_range(400, 20));
    c.entrance   = LAT_W'($urandom_range(40, 1));
    c.intershock = LAT_W'($urandom_range(40, 1));
    c.duration   = LAT_W'($urandom_range(40, 1));
    c.refractory = LAT_W'($urandom_range(40, 1));
    c.level      = LVL_W'($urandom);
    c.enable     = 1'b1;
    case (k)
      0: c = '{12'd4095, 16'd0, 16'd0, 16'd0, 16'd0, 3'd7, 1'b1};
      2: c.enable = 1'b0;
      3: begin
        c.entrance   = 16'hffff;
        c.intershock = 16'hffff;
        c.duration   = 16'hffff;
        c.refractory = 16'hffff;
      end
      5: begin
        c.radius = '0;
        c.level  = '0;
      end
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    int tail;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_config('{12'd100, 16'd20, 16'd15, 16'd10, 16'd30, 3'd5, 1'b1});
    add_frame(0, 0, 2000, 2000, 1, 2000, 2000);          // subject lost
    add_frame(1, 1, 2000, 2000, 0, 2000, 2000);          // target lost
    add_frame(2, 0, 4095, 4095, 0, 4095, 4095);          // both lost
    add_frame(3, 1, 0, 0, 1, 4095, 4095);
    add_frame(4, 1, 4095, 0, 1, 0, 4095);
    add_frame(10, 1, 2000, 2050, 1, 2000, 2000);         // entry
    add_frame(30, 1, 2000, 2050, 1, 2000, 2000);         // elapsed equals latency: hold
    add_frame(31, 1, 2000, 2050, 1, 2000, 2000);         // first shock
    add_frame(35, 0, 2000, 2050, 1, 2000, 2000);
    add_frame(42, 1, 2000, 2050, 0, 2000, 2000);         // bad frame ends drive only
    add_frame(43, 1, 2000, 2050, 1, 2000, 2000);         // into pause
    add_frame(50, 1, 2000, 2050, 1, 2000, 2000);
    add_frame(52, 0, 2000, 2050, 0, 2000, 2000);         // bad frame in pause
    add_frame(40, 1, 2000, 2050, 1, 2000, 2000);         // time goes backwards
    add_frame(59, 1, 2000, 2050, 1, 2000, 2000);         // second shock
    add_frame(70, 1, 100, 100, 1, 2000, 2000);           // leave: refractory
    add_frame(80, 1, 2000, 2050, 1, 2000, 2000);
    add_frame(101, 1, 2000, 2050, 1, 2000, 2000);        // back outside
    add_frame(102, 1, 2000, 2050, 1, 2000, 2000);        // second entry
    add_frame(103, 1, 3000, 3000, 1, 2000, 2000);        // left during latency
    add_frame(104, 1, 2100, 2000, 1, 2000, 2000);        // distance equals radius
    add_frame(32'hffffffff, 1, 4095, 4000, 1, 4095, 4095);
    add_frame(32'hffffffff, 1, 4095, 4000, 1, 4095, 4095);
    add_frame(5, 1, 4095, 4000, 1, 4095, 4095);          // latency sum must not wrap
    add_frame(6, 1, 4095, 4000, 0, 4095, 4095);
    send_frames();
    drain();

    for (int k = 0; k < 6; k++) begin
      if (k == 2) begin
        send_idle_pct = 57;
        recv_idle_pct <= 34;
      end
      if (k == 4) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      write_config(phase_config(k));
      cur_ts = $urandom;
      for (int i = 0; i < PHASE_ITEMS; i++) frames_to_send = {frames_to_send, make_frame()};
      // long receiver hold-off while frames keep coming, so s_tready must drop
      if (k == 4) pressure_armed <= 1'b1;
      send_frames();
      drain();
    end

    tail = 0;
    while (sb.pending() > 0 && tail < 2000) begin
      @(posedge clk);
      tail++;
    end
    repeat (10) @(posedge clk);
    if (sb.pending() > 0) begin
      $error("%0d expected result beats never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pss_pkg.sv
rtl/proximity_shock_sequencer.sv
rtl/pss_checker.sv
dv/proximity_shock_sequencer_tb.sv
